### rtl/core/sra_pkg.sv
// Package for the SPI register access master: payload structs, command codes,
// phase enum, configuration struct and frame byte selection.
// No dependencies.
package sra_pkg;

    localparam int FRAME_BYTES = 3;
    localparam logic [9:0] HALF_PERIOD_RST = 10'd100;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_REG_RD   = 3'd1;
    localparam logic [2:0] OP_REG_WR   = 3'd2;
    localparam logic [2:0] OP_FIELD_WR = 3'd3;
    localparam logic [2:0] OP_XCHG     = 3'd4;

    localparam logic REG_SLAVE_SELECT = 1'b0;
    localparam logic REG_HALF_PERIOD  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEAD = 3'd1,
        PH_HIGH = 3'd2,
        PH_LOW  = 3'd3,
        PH_GAP  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [2:0]  op;
        logic        miso;
        logic [14:0] reg_addr;
        logic [7:0]  data_byte;
        logic [7:0]  field_mask;
        logic [2:0]  field_shift;
    } t_in;

    typedef struct packed {
        logic       sclk;
        logic       mosi;
        logic       cs0_n;
        logic       cs1_n;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } t_out;

    typedef struct packed {
        logic       slave_select;
        logic [9:0] half_period;
    } t_cfg;

    // Byte idx of the frame for the given command.
    function automatic logic [7:0] frame_byte(input logic [2:0]  cmd,
                                              input logic [1:0]  idx,
                                              input logic [14:0] addr,
                                              input logic [7:0]  data);
        logic [7:0] b;
        b = 8'h00;
        if (cmd == OP_XCHG) begin
            b = data;
        end else if (idx == 2'd0) begin
            b = {(cmd == OP_REG_WR), addr[14:8]};
        end else if (idx == 2'd1) begin
            b = addr[7:0];
        end else if (idx == 2'd2 && cmd == OP_REG_WR) begin
            b = data;
        end
        return b;
    endfunction

    function automatic logic [1:0] frame_len(input logic [2:0] cmd);
        return (cmd == OP_XCHG) ? 2'd1 : 2'(FRAME_BYTES);
    endfunction

endpackage

### rtl/core/sra_regs.sv
// APB-style configuration registers: slave_select and half_period.
// Depends on sra_pkg.
module sra_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output sra_pkg::t_cfg o_cfg
);

    sra_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_select <= 1'b0;
            r_cfg.half_period  <= sra_pkg::HALF_PERIOD_RST;
        end else if (wr_en) begin
            if (paddr[2] == sra_pkg::REG_SLAVE_SELECT) begin
                r_cfg.slave_select <= pwdata[0];
            end else begin
                r_cfg.half_period <= pwdata[9:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == sra_pkg::REG_HALF_PERIOD) begin
            prdata = {22'd0, r_cfg.half_period};
        end else begin
            prdata = {31'd0, r_cfg.slave_select};
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/spi_register_access_master.sv
// Top level of the SPI register access master (mode 0, MSB first, tick paced).
// Depends on sra_pkg and sra_regs.
//
//  channel | dir | payload        | handshake
//  in      | in  | sra_pkg::t_in  | i_in_valid / o_in_stall
//  out     | out | sra_pkg::t_out | o_out_valid / i_out_stall
//  cfg     | in  | APB, 2 regs    | psel / penable / pwrite / pready
//
// One transaction per cycle while not stalled; each accepted item yields one registered result.
// The SPI state update is one pass of logic from the state registers to the result register.
// Input is stalled only while a result is held and the output side stalls.
// Synchronous active-low reset clears the sequencer and the output valid.
module spi_register_access_master (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sra_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sra_pkg::t_out o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    sra_pkg::t_cfg   cfg;

    sra_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_cmd, n_cmd;
    logic [2:0]      r_bit, n_bit;
    logic [1:0]      r_byte, n_byte;
    logic [9:0]      r_div, n_div;
    logic [7:0]      r_tx, n_tx;
    logic [7:0]      r_rx, n_rx;
    logic [14:0]     r_addr, n_addr;
    logic [7:0]      r_data, n_data;
    logic [7:0]      r_mask, n_mask;
    logic [2:0]      r_shift, n_shift;
    logic [7:0]      r_last, n_last;
    logic            n_done;
    logic            r_out_valid;
    sra_pkg::t_out   r_out, n_out;

    logic            accept;
    logic [9:0]      div_inc;
    logic            half_done;
    logic [1:0]      byte_inc;
    logic [7:0]      shifted;
    logic            active;

    sra_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign div_inc   = r_div + 10'd1;
    assign half_done = (div_inc >= cfg.half_period) || (div_inc == 10'd0);
    assign byte_inc  = r_byte + 2'd1;
    assign shifted   = r_data << r_shift;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_div   = r_div;
        n_tx    = r_tx;
        n_rx    = r_rx;
        n_addr  = r_addr;
        n_data  = r_data;
        n_mask  = r_mask;
        n_shift = r_shift;
        n_last  = r_last;
        n_done  = 1'b0;
        if (r_phase != sra_pkg::PH_IDLE) begin
            n_div = half_done ? 10'd0 : div_inc;
        end
        case (r_phase)
            sra_pkg::PH_IDLE: begin
                if (i_in.op inside {[sra_pkg::OP_REG_RD:sra_pkg::OP_XCHG]}) begin
                    n_cmd   = i_in.op;
                    n_addr  = i_in.reg_addr;
                    n_data  = i_in.data_byte;
                    n_mask  = i_in.field_mask;
                    n_shift = i_in.field_shift;
                    n_rx    = 8'd0;
                    n_byte  = 2'd0;
                    n_bit   = 3'd7;
                    n_tx    = sra_pkg::frame_byte(i_in.op, 2'd0, i_in.reg_addr,
                                                  i_in.data_byte);
                    n_div   = 10'd0;
                    n_phase = sra_pkg::PH_LEAD;
                end
            end
            sra_pkg::PH_LEAD: begin
                if (half_done) begin
                    n_phase = sra_pkg::PH_HIGH;
                end
            end
            sra_pkg::PH_HIGH: begin
                if (half_done) begin
                    n_rx    = {r_rx[6:0], i_in.miso};
                    n_phase = sra_pkg::PH_LOW;
                    if (r_bit != 3'd0) begin
                        n_bit = r_bit - 3'd1;
                    end else begin
                        n_byte = byte_inc;
                        if (byte_inc < sra_pkg::frame_len(r_cmd)) begin
                            n_tx  = sra_pkg::frame_byte(r_cmd, byte_inc, r_addr, r_data);
                            n_bit = 3'd7;
                        end
                    end
                end
            end
            sra_pkg::PH_LOW: begin
                if (half_done) begin
                    if (r_byte < sra_pkg::frame_len(r_cmd)) begin
                        n_phase = sra_pkg::PH_HIGH;
                    end else if (r_cmd == sra_pkg::OP_FIELD_WR) begin
                        n_data  = (r_rx & ~r_mask) | (shifted & r_mask);
                        n_cmd   = sra_pkg::OP_REG_WR;
                        n_byte  = 2'd0;
                        n_phase = sra_pkg::PH_GAP;
                    end else begin
                        if (r_cmd == sra_pkg::OP_REG_RD || r_cmd == sra_pkg::OP_XCHG) begin
                            n_last = r_rx;
                        end
                        n_cmd   = sra_pkg::OP_TICK;
                        n_phase = sra_pkg::PH_IDLE;
                        n_bit   = 3'd7;
                        n_byte  = 2'd0;
                        n_done  = 1'b1;
                    end
                end
            end
            sra_pkg::PH_GAP: begin
                if (half_done) begin
                    n_byte  = 2'd0;
                    n_bit   = 3'd7;
                    n_tx    = sra_pkg::frame_byte(r_cmd, 2'd0, r_addr, r_data);
                    n_div   = 10'd0;
                    n_phase = sra_pkg::PH_LEAD;
                end
            end
            default: begin
                n_phase = sra_pkg::PH_IDLE;
                n_cmd   = sra_pkg::OP_TICK;
            end
        endcase
    end

    // pin levels after the item
    always_comb begin
        active = (n_phase == sra_pkg::PH_LEAD) || (n_phase == sra_pkg::PH_HIGH) ||
                 (n_phase == sra_pkg::PH_LOW);
        n_out.sclk      = (n_phase == sra_pkg::PH_HIGH);
        n_out.mosi      = active ? n_tx[n_bit] : 1'b1;
        n_out.cs0_n     = ~(active & ~cfg.slave_select);
        n_out.cs1_n     = ~(active & cfg.slave_select);
        n_out.busy_res  = (n_phase != sra_pkg::PH_IDLE);
        n_out.done_res  = n_done;
        n_out.read_byte = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sra_pkg::PH_IDLE;
            r_cmd       <= sra_pkg::OP_TICK;
            r_bit       <= 3'd7;
            r_byte      <= 2'd0;
            r_div       <= 10'd0;
            r_tx        <= 8'd0;
            r_rx        <= 8'd0;
            r_addr      <= 15'd0;
            r_data      <= 8'd0;
            r_mask      <= 8'd0;
            r_shift     <= 3'd0;
            r_last      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_bit   <= n_bit;
                r_byte  <= n_byte;
                r_div   <= n_div;
                r_tx    <= n_tx;
                r_rx    <= n_rx;
                r_addr  <= n_addr;
                r_data  <= n_data;
                r_mask  <= n_mask;
                r_shift <= n_shift;
                r_last  <= n_last;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for spi_register_access_master: random tick and command
// streams against an in-bench pin-level predictor, APB writes between phases.
// Depends on sra_pkg and the spi_register_access_master RTL.
module testbench;

    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
    localparam logic [2:0] ADDR_SLAVE_SELECT = {sra_pkg::REG_SLAVE_SELECT, 2'b00};
    localparam logic [2:0] ADDR_HALF_PERIOD  = {sra_pkg::REG_HALF_PERIOD, 2'b00};
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS = 40;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    sra_pkg::t_in  i_in = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    sra_pkg::t_out o_out;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    spi_register_access_master u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    sra_pkg::t_in  tick_feed[$];
    sra_pkg::t_out predicted_pins[$];
    int   fed = 0;
    int   mismatches = 0;
    int   cycles = 0;
    int   quiet_cycles = 0;
    int   gen_hp = 0;
    bit   quiet = 1'b0;
    bit   in_fire = 1'b0;
    int   in_gap = 0;
    int   stall_left = 0;

    // shadow of the SPI sequencer
    logic            cfg_ss;
    logic [9:0]      cfg_hp;
    logic [2:0]      cur_cmd;
    sra_pkg::t_phase cur_phase;
    logic [2:0]      bit_pos;
    logic [1:0]      byte_pos;
    logic [9:0]      div_cnt;
    logic [7:0]      tx_byte;
    logic [7:0]      rx_byte;
    logic [14:0]     hold_addr;
    logic [7:0]      hold_data;
    logic [7:0]      hold_mask;
    logic [2:0]      hold_shift;
    logic [7:0]      read_back;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void spi_clear();
        cfg_ss = 1'b0;
        cfg_hp = sra_pkg::HALF_PERIOD_RST;
        cur_cmd = sra_pkg::OP_TICK;
        cur_phase = sra_pkg::PH_IDLE;
        bit_pos = 3'd7;
        byte_pos = 2'd0;
        div_cnt = '0;
        tx_byte = '0;
        rx_byte = '0;
        hold_addr = '0;
        hold_data = '0;
        hold_mask = '0;
        hold_shift = '0;
        read_back = '0;
    endfunction

    function automatic logic [7:0] tx_byte_for(input logic [1:0] idx);
        if (cur_cmd == sra_pkg::OP_XCHG) return hold_data;
        if (idx == 2'd0) return {cur_cmd == sra_pkg::OP_REG_WR, hold_addr[14:8]};
        if (idx == 2'd1) return hold_addr[7:0];
        if (idx == 2'd2 && cur_cmd == sra_pkg::OP_REG_WR) return hold_data;
        return 8'h00;
    endfunction

    function automatic logic [1:0] bytes_in_frame();
        return (cur_cmd == sra_pkg::OP_XCHG) ? 2'd1 : 2'(sra_pkg::FRAME_BYTES);
    endfunction

    function automatic void begin_frame();
        byte_pos = 2'd0;
        bit_pos = 3'd7;
        tx_byte = tx_byte_for(2'd0);
        div_cnt = '0;
        cur_phase = sra_pkg::PH_LEAD;
    endfunction

    function automatic bit half_tick();
        div_cnt = div_cnt + 10'd1;
        if (div_cnt >= cfg_hp || div_cnt == 10'd0) begin
            div_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sra_pkg::t_out spi_advance(input sra_pkg::t_in it);
        sra_pkg::t_out r;
        logic active;
        logic done;
        done = 1'b0;
        case (cur_phase)
            sra_pkg::PH_IDLE: begin
                if (it.op >= sra_pkg::OP_REG_RD && it.op <= sra_pkg::OP_XCHG) begin
                    cur_cmd = it.op;
                    hold_addr = it.reg_addr;
                    hold_data = it.data_byte;
                    hold_mask = it.field_mask;
                    hold_shift = it.field_shift;
                    rx_byte = '0;
                    begin_frame();
                end
            end
            sra_pkg::PH_LEAD: begin
                if (half_tick()) cur_phase = sra_pkg::PH_HIGH;
            end
            sra_pkg::PH_HIGH: begin
                if (half_tick()) begin
                    rx_byte = {rx_byte[6:0], it.miso};
                    cur_phase = sra_pkg::PH_LOW;
                    if (bit_pos > 3'd0) begin
                        bit_pos = bit_pos - 3'd1;
                    end else begin
                        byte_pos = byte_pos + 2'd1;
                        if (byte_pos < bytes_in_frame()) begin
                            tx_byte = tx_byte_for(byte_pos);
                            bit_pos = 3'd7;
                        end
                    end
                end
            end
            sra_pkg::PH_LOW: begin
                if (half_tick()) begin
                    if (byte_pos < bytes_in_frame()) begin
                        cur_phase = sra_pkg::PH_HIGH;
                    end else if (cur_cmd == sra_pkg::OP_FIELD_WR) begin
                        // read-modify-write: merge then reissue as a register write
                        hold_data = (rx_byte & ~hold_mask) |
                                    ((hold_data << hold_shift) & hold_mask);
                        cur_cmd = sra_pkg::OP_REG_WR;
                        byte_pos = 2'd0;
                        cur_phase = sra_pkg::PH_GAP;
                    end else begin
                        if (cur_cmd == sra_pkg::OP_REG_RD || cur_cmd == sra_pkg::OP_XCHG)
                            read_back = rx_byte;
                        cur_cmd = sra_pkg::OP_TICK;
                        cur_phase = sra_pkg::PH_IDLE;
                        bit_pos = 3'd7;
                        byte_pos = 2'd0;
                        done = 1'b1;
                    end
                end
            end
            sra_pkg::PH_GAP: begin
                if (half_tick()) begin_frame();
            end
            default: begin
                cur_phase = sra_pkg::PH_IDLE;
                cur_cmd = sra_pkg::OP_TICK;
            end
        endcase
        active = (cur_phase == sra_pkg::PH_LEAD || cur_phase == sra_pkg::PH_HIGH ||
                  cur_phase == sra_pkg::PH_LOW);
        r.sclk = (cur_phase == sra_pkg::PH_HIGH);
        r.mosi = active ? tx_byte[bit_pos] : 1'b1;
        r.cs0_n = !(active && cfg_ss == 1'b0);
        r.cs1_n = !(active && cfg_ss == 1'b1);
        r.busy_res = (cur_phase != sra_pkg::PH_IDLE);
        r.done_res = done;
        r.read_byte = read_back;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s at cycle %0d: expected %0h, got %0h",
                         name, cycles, want, got);
        end
    endtask

    task automatic check_result(input sra_pkg::t_out want, input sra_pkg::t_out got);
        check_field("sclk", 8'(want.sclk), 8'(got.sclk));
        check_field("mosi", 8'(want.mosi), 8'(got.mosi));
        check_field("cs0_n", 8'(want.cs0_n), 8'(got.cs0_n));
        check_field("cs1_n", 8'(want.cs1_n), 8'(got.cs1_n));
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("read_byte", want.read_byte, got.read_byte);
    endtask

    // monitor and predictor
    always @(posedge i_clk) begin
        cycles++;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            quiet_cycles <= 0;
            spi_clear();
        end else begin
            in_fire <= i_in_valid && !o_in_stall;
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_SLAVE_SELECT) cfg_ss = pwdata[0];
                else if (paddr == ADDR_HALF_PERIOD) cfg_hp = pwdata[9:0];
            end
            if (o_out_valid && !i_out_stall) begin
                if (predicted_pins.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction at cycle %0d: %0h", cycles, o_out);
                end else begin
                    check_result(predicted_pins.pop_front(), o_out);
                end
            end
            if (i_in_valid && !o_in_stall)
                predicted_pins.push_back(spi_advance(i_in));
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (!quiet && (cycles / 300) % 4 != 3 && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(0, 5);
                i_in_valid <= 1'b0;
            end else if (tick_feed.size() != 0) begin
                i_in <= tick_feed.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && (cycles / 300) % 4 != 1 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("testbench: done, errors");
        $finish;
    end

    function automatic sra_pkg::t_in random_item(input logic [2:0] op);
        sra_pkg::t_in it;
        it.op = op;
        it.miso = 1'($urandom_range(0, 1));
        it.reg_addr = 15'($urandom);
        it.data_byte = 8'($urandom);
        it.field_mask = 8'($urandom);
        it.field_shift = 3'($urandom);
        return it;
    endfunction

    function automatic logic [2:0] idle_op();
        if ($urandom_range(0, 1) == 0) return sra_pkg::OP_TICK;
        return 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    endfunction

    task automatic push_item(input sra_pkg::t_in it);
        tick_feed.push_back(it);
        fed++;
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic ss, input int hp);
        reg_write(ADDR_SLAVE_SELECT, 32'(ss));
        reg_write(ADDR_HALF_PERIOD, 32'(hp));
        gen_hp = hp;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (tick_feed.size() != 0 || i_in_valid || predicted_pins.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // command transaction followed by just enough ticks to finish it
    task automatic run_cmd(input logic [2:0] op, input logic [14:0] addr,
                           input logic [7:0] data, input logic [7:0] mask,
                           input logic [2:0] shift);
        sra_pkg::t_in it;
        int busy;
        int eh;
        it = random_item(op);
        it.reg_addr = addr;
        it.data_byte = data;
        it.field_mask = mask;
        it.field_shift = shift;
        push_item(it);
        eh = (gen_hp == 0) ? 1 : gen_hp;
        case (op)
            sra_pkg::OP_REG_RD, sra_pkg::OP_REG_WR: busy = 49 * eh;
            sra_pkg::OP_FIELD_WR:                   busy = 99 * eh;
            sra_pkg::OP_XCHG:                       busy = 17 * eh;
            default:                                busy = 0;
        endcase
        repeat (busy)
            push_item(random_item(3'($urandom_range(sra_pkg::OP_TICK, OP_RSVD_LAST))));
        repeat ($urandom_range(0, 2)) push_item(random_item(idle_op()));
    endtask

    task automatic random_cmd();
        logic [14:0] addr;
        case ($urandom_range(0, 7))
            0:       addr = 15'h0000;
            1:       addr = 15'h7FFF;
            default: addr = 15'($urandom);
        endcase
        if ($urandom_range(0, 5) == 0)
            push_item(random_item(idle_op()));
        else
            run_cmd(3'($urandom_range(sra_pkg::OP_REG_RD, sra_pkg::OP_XCHG)), addr,
                    8'($urandom), 8'($urandom), 3'($urandom));
    endtask

    initial begin
        int ph;
        int target;
        bit paused;
        sra_pkg::t_in it;
        paused = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        gen_hp = sra_pkg::HALF_PERIOD_RST;

        // reset divider through the lead, then the slowest divider, then the fastest
        it = random_item(sra_pkg::OP_XCHG);
        it.data_byte = 8'hA5;
        push_item(it);
        repeat (120) push_item(random_item(sra_pkg::OP_TICK));
        drain();
        set_config(1'b0, 1023);
        repeat (30) push_item(random_item(sra_pkg::OP_TICK));
        drain();
        set_config(1'b0, 1);
        repeat (20) push_item(random_item(sra_pkg::OP_TICK));
        drain();

        // zero half period acts as one
        set_config(1'b1, 0);
        run_cmd(sra_pkg::OP_REG_RD, 15'h7FFF, 8'h00, 8'h00, 3'd0);
        run_cmd(sra_pkg::OP_REG_RD, 15'h0000, 8'hFF, 8'hFF, 3'd7);
        run_cmd(sra_pkg::OP_REG_WR, 15'h7FFF, 8'hFF, 8'h00, 3'd0);
        run_cmd(sra_pkg::OP_REG_WR, 15'h0000, 8'h00, 8'hFF, 3'd7);
        run_cmd(sra_pkg::OP_FIELD_WR, 15'h7FFF, 8'hFF, 8'hFF, 3'd7);
        run_cmd(sra_pkg::OP_FIELD_WR, 15'h2AAA, 8'hFF, 8'h00, 3'd0);
        run_cmd(sra_pkg::OP_FIELD_WR, 15'h5555, 8'h0F, 8'hF0, 3'd4);
        run_cmd(sra_pkg::OP_XCHG, 15'h0000, 8'h00, 8'h00, 3'd0);
        run_cmd(sra_pkg::OP_XCHG, 15'h7FFF, 8'hFF, 8'hFF, 3'd7);
        run_cmd(OP_RSVD_FIRST, 15'h1234, 8'h12, 8'h34, 3'd1);
        run_cmd(3'd6, 15'h7FFF, 8'hFF, 8'hFF, 3'd7);
        run_cmd(OP_RSVD_LAST, 15'h0000, 8'h00, 8'h00, 3'd0);
        run_cmd(sra_pkg::OP_TICK, 15'h7FFF, 8'hFF, 8'hFF, 3'd7);
        drain();

        // settings changed while a read is in flight
        set_config(1'b0, 1);
        push_item(random_item(sra_pkg::OP_REG_RD));
        repeat (20) push_item(random_item(3'($urandom_range(sra_pkg::OP_TICK, OP_RSVD_LAST))));
        drain();
        set_config(1'b1, 2);
        repeat (70) push_item(random_item(sra_pkg::OP_TICK));

        for (ph = 0; ph < 5; ph++) begin
            drain();
            set_config(1'(ph % 2), (ph == 4) ? $urandom_range(1, 2) : (ph % 2) + 1);
            target = fed + PHASE_ITEMS;
            while (fed < target) begin
                random_cmd();
                if (ph == 2 && !paused && fed > target - PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        set_config(1'b0, 1);
        quiet = 1'b1;
        repeat (2) random_cmd();
        drain();
        repeat (8) @(posedge i_clk);
        if (predicted_pins.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
